// ===== hdl/adjacency_matrix_degree_defines.svh =====
// assertion macros shared by the adjacency matrix degree block
`ifndef ADJACENCY_MATRIX_DEGREE_DEFINES_SVH
`define ADJACENCY_MATRIX_DEGREE_DEFINES_SVH

`ifndef SYNTH

`define AMD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AMD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AMD_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define AMD_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/amd_pkg.sv =====
// shared types and constants of the adjacency matrix degree block
package amd_pkg;

    localparam int NO_EDGE    = 100;
    localparam int MODE_W     = 2;
    localparam int VERTEX_W   = 5;
    localparam int COST_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int DEGREE_W   = 6;
    localparam int DEGREE_MAX = 31;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_VERTEX  = 2'd0,
        MODE_INSERT_EDGE = 2'd1,
        MODE_DEGREE      = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE_B,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                       vld;
        t_status                    status;
        logic signed [DEGREE_W-1:0] degree;
    } t_result;

endpackage

// ===== hdl/adjacency_matrix_degree.sv =====
// adjacency matrix degree: undirected weighted graph with vertex count and degree queries
//
// input channel: i_in_valid / o_in_stall carry mode, vertex_a, vertex_b and edge_cost;
// output channel: o_out_valid / i_out_stall carry status and degree, one per input.
// a transfer happens on a rising edge with valid high and stall low.
// one operation is in flight at a time; the weight matrix sits in a single
// synchronous memory (one write, one registered read per cycle).
// add vertex and out-of-range operations: S_RESULT, then the output register.
// insert edge: the two mirrored writes share the one write port (idle, then S_WRITE_B).
// degree query: S_SCAN reads one row entry per cycle over the vertex_count entries,
// then S_DRAIN and S_RESULT; on an empty graph it goes straight to S_RESULT.
// after reset the memory is swept once, one entry per cycle, over all
// MAX_VERTICES * MAX_VERTICES entries; o_in_stall stays high during the sweep.
// a finished result sits in the output register; while the receiver stalls,
// the block may accept the next item and works it up to its result, then waits.
`include "adjacency_matrix_degree_defines.svh"

module adjacency_matrix_degree import amd_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [VERTEX_W-1:0]        i_vertex_a,
    input  logic [VERTEX_W-1:0]        i_vertex_b,
    input  logic signed [COST_W-1:0]   i_edge_cost,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DEGREE_W-1:0] o_degree
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    t_result                    w_result;
    logic                       w_out_free;
    logic                       w_mem_we;
    logic [AW-1:0]              w_mem_waddr;
    logic [WEIGHT_WIDTH-1:0]    w_mem_wdata;
    logic [AW-1:0]              w_mem_raddr;
    logic [WEIGHT_WIDTH-1:0]    w_mem_rdata;

    logic                       r_out_vld;
    t_status                    r_status;
    logic signed [DEGREE_W-1:0] r_degree;

    assign w_out_free = !r_out_vld || !i_out_stall;

    amd_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .i_edge_cost (i_edge_cost),
        .i_out_free  (w_out_free),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    amd_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WEIGHT_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_result.vld && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.vld && w_out_free) begin
            r_status <= w_result.status;
            r_degree <= w_result.degree;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_degree    = r_degree;

    // one operation at a time: the block is busy right after an input transfer
    `AMD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // only a successful query carries a degree
    `AMD_ASSERT_IMP(a_degree_zero_on_error, i_clk, i_rst_n,
                    o_out_valid && (o_status != ST_OK), o_degree == '0)
    // no matrix write while a result is pending
    `AMD_ASSERT_IMP(a_no_write_at_result, i_clk, i_rst_n, w_result.vld, !w_mem_we)

endmodule

// ===== hdl/amd_mem.sv =====
// weight matrix storage: one write port, one registered read port
module amd_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/amd_ctrl.sv =====
// sequencer: clearing pass, vertex count, edge writes and row scan for degree queries
module amd_ctrl import amd_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_WIDTH = 16,
    localparam int RW = $clog2(MAX_VERTICES),
    localparam int CW = $clog2(MAX_VERTICES + 1),
    localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [VERTEX_W-1:0]     i_vertex_a,
    input  logic [VERTEX_W-1:0]     i_vertex_b,
    input  logic signed [COST_W-1:0] i_edge_cost,
    input  logic                    i_out_free,
    output t_result                 o_result,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output logic [WEIGHT_WIDTH-1:0] o_mem_wdata,
    output logic [AW-1:0]           o_mem_raddr,
    input  logic [WEIGHT_WIDTH-1:0] i_mem_rdata
);

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] row,
                                             input logic [RW-1:0] col);
        f_addr = AW'(row) * AW'(MAX_VERTICES) + AW'(col);
    endfunction

    t_state                  r_state, n_state;
    logic [RW-1:0]           r_row, n_row;
    logic [RW-1:0]           r_col, n_col;
    logic [CW-1:0]           r_vcount, n_vcount;
    logic [CW-1:0]           r_cnt, n_cnt;
    t_status                 r_status, n_status;
    logic                    r_is_query, n_is_query;
    logic [WEIGHT_WIDTH-1:0] r_wdata, n_wdata;
    logic                    r_rd_vld, n_rd_vld;

    t_mode                      w_mode;
    logic                       w_accept;
    logic                       w_a_in_range;
    logic                       w_b_in_range;
    logic                       w_a_in_matrix;
    logic [WEIGHT_WIDTH-1:0]    w_cost;
    logic                       w_hit;
    logic                       w_clr_row_end;
    logic                       w_clr_col_end;
    logic                       w_scan_end;
    logic signed [DEGREE_W-1:0] w_degree;

    assign w_mode        = t_mode'(i_mode);
    assign w_accept      = i_in_valid && (r_state == S_IDLE);
    assign w_a_in_range  = 32'(i_vertex_a) < 32'(r_vcount);
    assign w_b_in_range  = 32'(i_vertex_b) < 32'(r_vcount);
    assign w_a_in_matrix = 32'(i_vertex_a) < MAX_VERTICES;
    // sign extend the cost, then keep the stored width
    assign w_cost        = WEIGHT_WIDTH'(i_edge_cost);
    assign w_hit         = r_rd_vld && (i_mem_rdata != WEIGHT_WIDTH'(NO_EDGE));
    assign w_clr_row_end = 32'(r_row) == MAX_VERTICES - 1;
    assign w_clr_col_end = 32'(r_col) == MAX_VERTICES - 1;
    assign w_scan_end    = 32'(r_col) == 32'(r_vcount) - 1;

    // diagonal counts as one entry, so subtract it; saturate at the field limit
    assign w_degree = (32'(r_cnt) > DEGREE_MAX + 1) ? DEGREE_W'(DEGREE_MAX)
                                                    : DEGREE_W'(r_cnt) - DEGREE_W'(1);

    // next state
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_vcount   = r_vcount;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_is_query = r_is_query;
        n_wdata    = r_wdata;
        n_rd_vld   = (r_state == S_SCAN);
        if (w_hit) begin
            n_cnt = r_cnt + CW'(1);
        end
        unique case (r_state)
            S_CLEAR: begin
                if (w_clr_col_end) begin
                    n_col = '0;
                    if (w_clr_row_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + RW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt      = '0;
                    n_is_query = 1'b0;
                    n_status   = ST_OK;
                    n_state    = S_RESULT;
                    unique case (w_mode)
                        MODE_ADD_VERTEX: begin
                            if (32'(r_vcount) >= MAX_VERTICES) begin
                                n_status = ST_FULL;
                            end else begin
                                n_vcount = r_vcount + CW'(1);
                            end
                        end
                        MODE_INSERT_EDGE: begin
                            if (!(w_a_in_range && w_b_in_range)) begin
                                n_status = ST_RANGE;
                            end else begin
                                // mirrored entry is written in the next cycle
                                n_row   = RW'(i_vertex_b);
                                n_col   = RW'(i_vertex_a);
                                n_wdata = w_cost;
                                n_state = S_WRITE_B;
                            end
                        end
                        MODE_DEGREE: begin
                            if (!w_a_in_matrix) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_is_query = 1'b1;
                                if (r_vcount != '0) begin
                                    n_row   = RW'(i_vertex_a);
                                    n_col   = '0;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE_B: begin
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + RW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_mem_we    = 1'b0;
        o_mem_waddr = f_addr(r_row, r_col);
        o_mem_wdata = r_wdata;
        o_mem_raddr = f_addr(r_row, r_col);
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = (r_row == r_col) ? '0 : WEIGHT_WIDTH'(NO_EDGE);
            end
            S_IDLE: begin
                if (w_accept && (w_mode == MODE_INSERT_EDGE)
                        && w_a_in_range && w_b_in_range) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = f_addr(RW'(i_vertex_a), RW'(i_vertex_b));
                    o_mem_wdata = w_cost;
                end
            end
            S_WRITE_B: begin
                o_mem_we = 1'b1;
            end
            default: begin
            end
        endcase
        o_result.vld    = (r_state == S_RESULT);
        o_result.status = r_status;
        o_result.degree = r_is_query ? w_degree : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_row      <= '0;
            r_col      <= '0;
            r_vcount   <= '0;
            r_cnt      <= '0;
            r_status   <= ST_OK;
            r_is_query <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_vcount   <= n_vcount;
            r_cnt      <= n_cnt;
            r_status   <= n_status;
            r_is_query <= n_is_query;
            r_rd_vld   <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wdata <= n_wdata;
    end

endmodule

// ===== tb/adjacency_matrix_degree_checker.sv =====
`timescale 1ns / 100ps
// checker for the adjacency matrix degree block: tracks the graph and compares every answer
module adjacency_matrix_degree_checker import amd_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [VERTEX_W-1:0]        i_vertex_a,
    input  logic [VERTEX_W-1:0]        i_vertex_b,
    input  logic signed [COST_W-1:0]   i_edge_cost,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic signed [DEGREE_W-1:0] i_degree,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct {
        t_status                    status;
        logic signed [DEGREE_W-1:0] degree;
    } t_graph_answer;

    logic [WEIGHT_WIDTH-1:0] weights [MAX_VERTICES][MAX_VERTICES];
    int                      vertex_count;
    t_graph_answer           awaited_answers [$];
    int                      mismatches = 0;

    task automatic clear_graph();
        int r;
        int c;
        for (r = 0; r < MAX_VERTICES; r++) begin
            for (c = 0; c < MAX_VERTICES; c++) begin
                weights[r][c] = (r == c) ? '0 : WEIGHT_WIDTH'(NO_EDGE);
            end
        end
        vertex_count = 0;
        awaited_answers.delete();
    endtask

    // work out the answer of one operation and update the graph copy
    task automatic apply_graph_op(
        input logic [MODE_W-1:0]        mode,
        input logic [VERTEX_W-1:0]      va,
        input logic [VERTEX_W-1:0]      vb,
        input logic signed [COST_W-1:0] cost
    );
        t_graph_answer      answer;
        logic signed [31:0] wide_cost;
        int                 edges;
        int                 i;
        answer.status = ST_OK;
        answer.degree = '0;
        // cost is sign extended, then cut to the stored width
        wide_cost = cost;
        case (mode)
            MODE_ADD_VERTEX: begin
                if (vertex_count >= MAX_VERTICES) begin
                    answer.status = ST_FULL;
                end else begin
                    vertex_count++;
                end
            end
            MODE_INSERT_EDGE: begin
                if (va >= vertex_count || vb >= vertex_count) begin
                    answer.status = ST_RANGE;
                end else begin
                    weights[va][vb] = wide_cost[WEIGHT_WIDTH-1:0];
                    weights[vb][va] = wide_cost[WEIGHT_WIDTH-1:0];
                end
            end
            MODE_DEGREE: begin
                if (va >= MAX_VERTICES) begin
                    answer.status = ST_RANGE;
                end else begin
                    // start at -1 so the diagonal entry is not counted
                    edges = -1;
                    for (i = 0; i < vertex_count; i++) begin
                        if (weights[va][i] != WEIGHT_WIDTH'(NO_EDGE)) edges++;
                    end
                    if (edges > DEGREE_MAX) edges = DEGREE_MAX;
                    answer.degree = edges[DEGREE_W-1:0];
                end
            end
            default: ;
        endcase
        awaited_answers.push_back(answer);
    endtask

    always @(posedge i_clk) begin
        t_graph_answer oldest;
        if (!i_rst_n) begin
            clear_graph();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_answers.size() == 0) begin
                    $error("result with no operation waiting: status %0d, degree %0d",
                           i_status, i_degree);
                    mismatches++;
                end else begin
                    oldest = awaited_answers.pop_front();
                    if (i_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_status);
                        mismatches++;
                    end
                    if (i_degree !== oldest.degree) begin
                        $error("degree: expected %0d, actual %0d", oldest.degree, i_degree);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_graph_op(i_mode, i_vertex_a, i_vertex_b, i_edge_cost);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_answers.size();
    end

endmodule

// ===== tb/adjacency_matrix_degree_test.sv =====
`timescale 1ns / 100ps
// testbench top: clock, reset and traffic for the adjacency matrix degree block, and the verdict
module adjacency_matrix_degree_test;
    import amd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int GRAPH_MAX    = 32;
    localparam int IDLE_PCT     = 35;
    localparam int RANDOM_OPS   = 320;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 48;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [MODE_W-1:0]          mode       = '0;
    logic [VERTEX_W-1:0]        vertex_a   = '0;
    logic [VERTEX_W-1:0]        vertex_b   = '0;
    logic signed [COST_W-1:0]   edge_cost  = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [DEGREE_W-1:0] degree;

    int   fail_count;
    int   pending;
    logic quiet         = 1'b0;
    int   graph_size    = 0;
    int   adds_sent     = 0;
    int   inserts_sent  = 0;
    int   queries_sent  = 0;
    int   unused_sent   = 0;
    int   outputs_taken = 0;
    int   hold_left     = 0;
    logic hold_done     = 1'b0;

    always #5 clk = ~clk;

    adjacency_matrix_degree DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (mode),
        .i_vertex_a  (vertex_a),
        .i_vertex_b  (vertex_b),
        .i_edge_cost (edge_cost),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_degree    (degree)
    );

    adjacency_matrix_degree_checker graph_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_mode       (mode),
        .i_vertex_a   (vertex_a),
        .i_vertex_b   (vertex_b),
        .i_edge_cost  (edge_cost),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_degree     (degree),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, one long hold-off so the block backs up its input
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) outputs_taken <= outputs_taken + 1;
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (outputs_taken >= HOLD_AFTER && !hold_done) begin
                out_stall <= 1'b1;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // offer one operation and wait for its transfer
    task automatic send_op(
        input logic [MODE_W-1:0]        m,
        input logic [VERTEX_W-1:0]      a,
        input logic [VERTEX_W-1:0]      b,
        input logic signed [COST_W-1:0] c
    );
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        vertex_a  <= a;
        vertex_b  <= b;
        edge_cost <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (m)
            MODE_ADD_VERTEX: begin
                adds_sent++;
                if (graph_size < GRAPH_MAX) graph_size++;
            end
            MODE_INSERT_EDGE: inserts_sent++;
            MODE_DEGREE:      queries_sent++;
            default:          unused_sent++;
        endcase
    endtask

    task automatic rand_op();
        int                       roll;
        logic [VERTEX_W-1:0]      a;
        logic [VERTEX_W-1:0]      b;
        logic signed [COST_W-1:0] c;
        roll = $urandom_range(99);
        a = VERTEX_W'($urandom);
        b = VERTEX_W'($urandom);
        c = COST_W'($urandom);
        if (roll < ((graph_size < GRAPH_MAX) ? 30 : 5)) begin
            send_op(MODE_ADD_VERTEX, a, b, c);
        end else if (roll < 65) begin
            // mostly endpoints that exist, the rest anywhere
            if (graph_size > 0 && $urandom_range(99) < 85) begin
                a = VERTEX_W'($urandom_range(graph_size - 1));
                b = VERTEX_W'($urandom_range(graph_size - 1));
            end
            case ($urandom_range(19))
                0, 1:    c = COST_W'(NO_EDGE);
                2:       c = 16'sh8000;
                3:       c = 16'sh7fff;
                default: ;
            endcase
            send_op(MODE_INSERT_EDGE, a, b, c);
        end else if (roll < 92) begin
            if (graph_size > 0 && $urandom_range(99) < 70) begin
                a = VERTEX_W'($urandom_range(graph_size - 1));
            end
            send_op(MODE_DEGREE, a, b, c);
        end else begin
            send_op(MODE_W'($urandom), a, b, c);
        end
    endtask

    // fill the table, connect one vertex to every vertex, then ask its degree
    task automatic build_dense_row(input logic [VERTEX_W-1:0] v);
        int                       j;
        logic signed [COST_W-1:0] c;
        while (graph_size < GRAPH_MAX) send_op(MODE_ADD_VERTEX, '0, '0, '0);
        for (j = 0; j < GRAPH_MAX; j++) begin
            c = COST_W'($urandom);
            if (c == NO_EDGE) c = '0;
            send_op(MODE_INSERT_EDGE, v, VERTEX_W'(j), c);
        end
        send_op(MODE_DEGREE, v, '0, '0);
    endtask

    initial begin : stimulus
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty graph, range errors, unused mode
        send_op(MODE_DEGREE, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_INSERT_EDGE, 5'd0, 5'd0, 16'sd1);
        send_op(MODE_UNUSED, 5'd31, 5'd31, -16'sd1);
        send_op(MODE_ADD_VERTEX, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_INSERT_EDGE, 5'd0, 5'd1, 16'sd7);
        send_op(MODE_INSERT_EDGE, 5'd1, 5'd0, 16'sd7);
        // self loop on the diagonal, then back to no edge
        send_op(MODE_INSERT_EDGE, 5'd0, 5'd0, 16'sd5);
        send_op(MODE_DEGREE, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_INSERT_EDGE, 5'd0, 5'd0, COST_W'(NO_EDGE));
        send_op(MODE_DEGREE, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_ADD_VERTEX, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_ADD_VERTEX, 5'd0, 5'd0, 16'sd0);
        send_op(MODE_ADD_VERTEX, 5'd31, 5'd31, 16'sh7fff);
        // cost extremes and an explicit no-edge write
        send_op(MODE_INSERT_EDGE, 5'd0, 5'd1, 16'sh8000);
        send_op(MODE_INSERT_EDGE, 5'd2, 5'd3, 16'sh7fff);
        send_op(MODE_INSERT_EDGE, 5'd1, 5'd2, 16'sd0);
        send_op(MODE_INSERT_EDGE, 5'd3, 5'd1, COST_W'(NO_EDGE));
        send_op(MODE_DEGREE, 5'd1, 5'd31, 16'sh8000);
        send_op(MODE_DEGREE, 5'd2, 5'd0, 16'sd0);
        // vertex not yet added
        send_op(MODE_DEGREE, 5'd31, 5'd0, 16'sd0);
        send_op(MODE_INSERT_EDGE, 5'd3, 5'd31, 16'sd9);

        for (n = 0; n < RANDOM_OPS; n++) begin
            quiet <= (n >= 200 && n < 270);
            if (n == 150 || n == 300) build_dense_row(VERTEX_W'($urandom));
            rand_op();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d vertex adds, %0d edge inserts, %0d degree queries, %0d unused-mode items",
                 adds_sent, inserts_sent, queries_sent, unused_sent);
        $display("graph reached %0d vertices, two fully connected rows, one %0d-cycle output hold",
                 graph_size, HOLD_LEN);
        if (pending != 0) $error("%0d answers never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/amd_pkg.sv
hdl/amd_mem.sv
hdl/amd_ctrl.sv
hdl/adjacency_matrix_degree.sv
tb/adjacency_matrix_degree_checker.sv
tb/adjacency_matrix_degree_test.sv
